[hw/rtl/bfdg_pkg.sv]
`default_nettype none

package bfdg_pkg;

    // Result coordinate format: signed Q16.8
    localparam int OUT_WIDTH   = 24;
    localparam int OUT_TDATA_W = 3 * OUT_WIDTH;

    typedef logic signed [OUT_WIDTH-1:0] coord_out_t;

    localparam coord_out_t OUT_MAX = 24'sh7FFFFF;
    localparam coord_out_t OUT_MIN = 24'sh800000;

    // step_log2 register
    localparam int                STEP_W          = 3;
    localparam logic [STEP_W-1:0] STEP_LOG2_RESET = 3'd4;

    // Register map: index taken from paddr[2]
    localparam int                   CFG_ADDR_W     = 3;
    localparam int                   CFG_DATA_W     = 32;
    localparam logic                 REG_STEP_LOG2  = 1'b0;

    // Divide by three: q = (u * DIV3_MUL) >> DIV3_SHIFT, exact for u < 2^27
    localparam int                   DIV_U_W    = 26;
    localparam int                   DIV3_SHIFT = 27;
    localparam logic [DIV_U_W-1:0]   DIV3_MUL   = 26'd44739243;
    // Three times 2^23: offset that makes the in-range quotient nonnegative
    localparam int                   DIV_BIAS   = 3 * (2 ** (OUT_WIDTH - 1));

endpackage

`default_nettype wire

[hw/rtl/bfdg_conv.sv]
`default_nettype none

// Converts an accumulator value scaled by 6*2^(3k) to a rounded, saturated Q16.8
// coordinate. Registered on load: round bias, scale shift, range check. Then:
// exact divide by three through a reciprocal multiply (captured by the caller).
module bfdg_conv
    import bfdg_pkg::*;
#(
    parameter int ACC_WIDTH   = 37,
    parameter int SHIFT_WIDTH = 5
) (
    input  wire logic                          aclk,
    input  wire logic                          load,
    input  wire logic signed [ACC_WIDTH-1:0]   acc_f,
    input  wire logic        [SHIFT_WIDTH-1:0] scale_log2,
    output coord_out_t                         coord
);

    localparam int GW = ACC_WIDTH + 10;
    localparam logic signed [GW-1:0] BIAS_G     = GW'(DIV_BIAS);
    localparam logic signed [GW-1:0] NEG_BIAS_G = -BIAS_G;

    logic signed [GW-1:0]          g_w;
    logic signed [GW-1:0]          m_w;
    logic signed [GW-1:0]          u_w;
    logic        [SHIFT_WIDTH-1:0] div_shift;
    logic        [DIV_U_W-1:0]     u_reg;
    logic                          sat_hi_reg;
    logic                          sat_lo_reg;
    logic        [2*DIV_U_W-1:0]   prod;
    logic        [OUT_WIDTH-1:0]   quot;

    // f*256 + S/2, then floor divide by 2*2^(3k); the remaining factor is three
    assign div_shift = scale_log2 + SHIFT_WIDTH'(1);
    assign g_w       = (GW'(acc_f) <<< 8) + (GW'(3) <<< scale_log2);
    assign m_w       = g_w >>> div_shift;
    assign u_w       = m_w + BIAS_G;

    always_ff @(posedge aclk) begin
        if (load) begin
            u_reg      <= u_w[DIV_U_W-1:0];
            sat_hi_reg <= (m_w >= BIAS_G);
            sat_lo_reg <= (m_w < NEG_BIAS_G);
        end
    end

    // Unsigned divide by three of the biased value, then remove the bias
    assign prod = u_reg * DIV3_MUL;
    assign quot = prod[DIV3_SHIFT +: OUT_WIDTH];

    always_comb begin
        priority if (sat_hi_reg) begin
            coord = OUT_MAX;
        end else if (sat_lo_reg) begin
            coord = OUT_MIN;
        end else begin
            coord = {~quot[OUT_WIDTH-1], quot[OUT_WIDTH-2:0]};
        end
    end

endmodule

`default_nettype wire

[hw/rtl/bspline_forward_difference_generator.sv]
`default_nettype none

// Channel   | Direction | Payload                                   | Marker
// ----------+-----------+-------------------------------------------+-------------------
// s_ (in)   | slave     | tdata: x_in, y_in, z_in (COORD_WIDTH each) | tuser: start_curve
// m_ (out)  | master    | tdata: x_out, y_out, z_out (24 bits each)  | tlast: last_point
// APB       | slave     | step_log2 at byte address 0                | -
//
// A control point that completes no segment is only stored in the window. One that
// completes a segment first runs the coefficient setup (COEF_A, COEF_B per axis), then
// for each curve point one shared per-axis update and converter pass over x, y, z
// (UPD, CV1, CV2) plus the output transaction; the start point of a curve skips UPD.
// Reset clears control state only; window contents are never read before written.
// A stalled m_ transaction holds the sequencer; s_tready is low until the last point
// of the segment has been taken.
module bspline_forward_difference_generator
    import bfdg_pkg::*;
#(
    parameter int COORD_WIDTH   = 16,
    parameter int MAX_STEP_LOG2 = 5
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    // s_tdata: x_in, y_in, z_in from bit 0 up, zero padded to bytes
    input  wire logic                                     s_tvalid,
    output logic                                          s_tready,
    input  wire logic [((3*COORD_WIDTH+7)/8)*8-1:0]       s_tdata,
    // s_tuser: start_curve
    input  wire logic [0:0]                               s_tuser,
    // m_tdata: x_out, y_out, z_out from bit 0 up
    output logic                                          m_tvalid,
    input  wire logic                                     m_tready,
    output logic [OUT_TDATA_W-1:0]                        m_tdata,
    output logic                                          m_tlast,
    // configuration
    input  wire logic                                     psel,
    input  wire logic                                     penable,
    input  wire logic                                     pwrite,
    input  wire logic [CFG_ADDR_W-1:0]                    paddr,
    input  wire logic [CFG_DATA_W-1:0]                    pwdata,
    output logic [CFG_DATA_W-1:0]                         prdata,
    output logic                                          pready
);

    localparam int CW   = COORD_WIDTH;
    localparam int CFW  = COORD_WIDTH + 4;
    localparam int AW   = COORD_WIDTH + 3 * MAX_STEP_LOG2 + 6;
    localparam int SW   = MAX_STEP_LOG2;
    localparam int SH_W = $clog2(3 * MAX_STEP_LOG2 + 2);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_COEF_A = 3'd1;
    localparam logic [2:0] ST_COEF_B = 3'd2;
    localparam logic [2:0] ST_UPD    = 3'd3;
    localparam logic [2:0] ST_CV1    = 3'd4;
    localparam logic [2:0] ST_CV2    = 3'd5;
    localparam logic [2:0] ST_EMIT   = 3'd6;

    localparam logic [1:0] AXIS_LAST = 2'd2;
    localparam logic [1:0] HELD_FULL = 2'd3;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        logic signed [AW-1:0] f;
        logic signed [AW-1:0] df;
        logic signed [AW-1:0] d2f;
        logic signed [AW-1:0] d3f;
    } acc_t;

    // control state
    logic [2:0]        state_reg, state_next;
    logic [1:0]        axis_reg, axis_next;
    logic [SW-1:0]     step_cnt_reg, step_cnt_next;
    logic [1:0]        held_reg, held_next;
    logic              first_pend_reg, first_pend_next;
    logic              start_pt_reg, start_pt_next;
    logic [STEP_W-1:0] step_log2_reg;

    // payload
    coord_t                win_reg [3][3];   // [position][axis], axes rotate
    coord_t                pnt_reg [3];
    logic signed [CFW-1:0] ca_reg, cb_reg, cc_reg, cd_reg;
    acc_t                  acc_reg [3];
    coord_out_t            out_reg [3];

    logic              in_xfer;
    logic              out_xfer;
    logic              cfg_wr;
    logic              last_w;
    coord_t            p_in [3];
    logic [STEP_W-1:0] k_eff;
    logic [SH_W-1:0]   k1, k2, k3;
    logic [SW:0]       steps_w;
    logic [SW-1:0]     steps_m1;
    coord_out_t        conv_coord;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;

    assign p_in[0] = s_tdata[CW-1:0];
    assign p_in[1] = s_tdata[2*CW-1:CW];
    assign p_in[2] = s_tdata[3*CW-1:2*CW];

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_STEP_LOG2)
                  ? {{(CFG_DATA_W-STEP_W){1'b0}}, step_log2_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_log2_reg <= STEP_LOG2_RESET;
        end else if (cfg_wr && (paddr[2] == REG_STEP_LOG2)) begin
            step_log2_reg <= pwdata[STEP_W-1:0];
        end
    end

    // step size, clamped to 1..MAX_STEP_LOG2
    always_comb begin
        priority if (step_log2_reg == '0) begin
            k_eff = STEP_W'(1);
        end else if (step_log2_reg > STEP_W'(MAX_STEP_LOG2)) begin
            k_eff = STEP_W'(MAX_STEP_LOG2);
        end else begin
            k_eff = step_log2_reg;
        end
    end

    assign k1       = SH_W'(k_eff);
    assign k2       = k1 << 1;
    assign k3       = k1 + k2;
    assign steps_w  = ((SW+1)'(1) << k_eff) - (SW+1)'(1);
    assign steps_m1 = steps_w[SW-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign last_w   = !start_pt_reg && (step_cnt_reg == steps_m1);
    assign m_tlast  = last_w;
    assign m_tdata  = {out_reg[2], out_reg[1], out_reg[0]};

    // sequencer
    always_comb begin
        state_next      = state_reg;
        axis_next       = axis_reg;
        step_cnt_next   = step_cnt_reg;
        held_next       = held_reg;
        first_pend_next = first_pend_reg;
        start_pt_next   = start_pt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    step_cnt_next = '0;
                    axis_next     = '0;
                    priority if (s_tuser[0]) begin
                        held_next       = 2'd1;
                        first_pend_next = 1'b1;
                    end else if (held_reg == HELD_FULL) begin
                        state_next = ST_COEF_A;
                    end else begin
                        held_next = held_reg + 2'd1;
                    end
                end
            end
            ST_COEF_A: begin
                state_next = ST_COEF_B;
            end
            ST_COEF_B: begin
                if (axis_reg == AXIS_LAST) begin
                    axis_next     = '0;
                    start_pt_next = first_pend_reg;
                    state_next    = first_pend_reg ? ST_CV1 : ST_UPD;
                end else begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_COEF_A;
                end
            end
            ST_UPD: begin
                state_next = ST_CV1;
            end
            ST_CV1: begin
                state_next = ST_CV2;
            end
            ST_CV2: begin
                if (axis_reg == AXIS_LAST) begin
                    axis_next  = '0;
                    state_next = ST_EMIT;
                end else begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = start_pt_reg ? ST_CV1 : ST_UPD;
                end
            end
            ST_EMIT: begin
                if (out_xfer) begin
                    priority if (last_w) begin
                        state_next = ST_IDLE;
                    end else if (start_pt_reg) begin
                        start_pt_next   = 1'b0;
                        first_pend_next = 1'b0;
                        state_next      = ST_UPD;
                    end else begin
                        step_cnt_next = step_cnt_reg + SW'(1);
                        state_next    = ST_UPD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            axis_reg       <= '0;
            step_cnt_reg   <= '0;
            held_reg       <= '0;
            first_pend_reg <= 1'b1;
            start_pt_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            axis_reg       <= axis_next;
            step_cnt_reg   <= step_cnt_next;
            held_reg       <= held_next;
            first_pend_reg <= first_pend_next;
            start_pt_reg   <= start_pt_next;
        end
    end

    // coefficients of the axis at position 0 (six times the cubic's)
    logic signed [CFW-1:0] q1, q2, q3, q4;
    logic signed [CFW-1:0] d41, d23, t_b, d31;
    logic signed [CFW-1:0] ca_w, cb_w, cc_w, cd_w;

    assign q1   = CFW'(win_reg[0][0]);
    assign q2   = CFW'(win_reg[1][0]);
    assign q3   = CFW'(win_reg[2][0]);
    assign q4   = CFW'(pnt_reg[0]);
    assign d41  = q4 - q1;
    assign d23  = q2 - q3;
    assign ca_w = d41 + (d23 <<< 1) + d23;
    assign t_b  = q1 - (q2 <<< 1) + q3;
    assign cb_w = t_b + (t_b <<< 1);
    assign d31  = q3 - q1;
    assign cc_w = d31 + (d31 <<< 1);
    assign cd_w = q1 + (q2 <<< 2) + q3;

    // initial differences at step 2^-k, scaled by 2^(3k)
    logic signed [AW-1:0] ca_e, cb_e, cc_e, cd_e, ca6;
    acc_t                 acc_init;

    assign ca_e = AW'(ca_reg);
    assign cb_e = AW'(cb_reg);
    assign cc_e = AW'(cc_reg);
    assign cd_e = AW'(cd_reg);
    assign ca6  = (ca_e <<< 2) + (ca_e <<< 1);

    always_comb begin
        acc_init.f   = cd_e <<< k3;
        acc_init.df  = ca_e + (cb_e <<< k1) + (cc_e <<< k2);
        acc_init.d2f = ca6 + (cb_e <<< (k1 + SH_W'(1)));
        acc_init.d3f = ca6;
    end

    // shared forward difference step for the axis at position 0
    acc_t acc_step;

    always_comb begin
        acc_step.f   = acc_reg[0].f + acc_reg[0].df;
        acc_step.df  = acc_reg[0].df + acc_reg[0].d2f;
        acc_step.d2f = acc_reg[0].d2f + acc_reg[0].d3f;
        acc_step.d3f = acc_reg[0].d3f;
    end

    // payload registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    for (int a = 0; a < 3; a++) begin
                        pnt_reg[a] <= p_in[a];
                    end
                    if (s_tuser[0]) begin
                        for (int a = 0; a < 3; a++) begin
                            win_reg[0][a] <= p_in[a];
                            win_reg[1][a] <= '0;
                            win_reg[2][a] <= '0;
                        end
                    end else if (held_reg != HELD_FULL) begin
                        for (int i = 0; i < 3; i++) begin
                            if (held_reg == 2'(i)) begin
                                for (int a = 0; a < 3; a++) begin
                                    win_reg[i][a] <= p_in[a];
                                end
                            end
                        end
                    end
                end
            end
            ST_COEF_A: begin
                ca_reg <= ca_w;
                cb_reg <= cb_w;
                cc_reg <= cc_w;
                cd_reg <= cd_w;
            end
            ST_COEF_B: begin
                // rotate axes so the next one sits at position 0
                acc_reg[0] <= acc_reg[1];
                acc_reg[1] <= acc_reg[2];
                acc_reg[2] <= acc_init;
                for (int i = 0; i < 3; i++) begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                    win_reg[i][2] <= win_reg[i][0];
                end
                pnt_reg[0] <= pnt_reg[1];
                pnt_reg[1] <= pnt_reg[2];
                pnt_reg[2] <= pnt_reg[0];
            end
            ST_UPD: begin
                acc_reg[0] <= acc_step;
            end
            ST_CV1: begin
            end
            ST_CV2: begin
                acc_reg[0] <= acc_reg[1];
                acc_reg[1] <= acc_reg[2];
                acc_reg[2] <= acc_reg[0];
                out_reg[0] <= out_reg[1];
                out_reg[1] <= out_reg[2];
                out_reg[2] <= conv_coord;
            end
            ST_EMIT: begin
                // slide the window once the segment is finished
                if (out_xfer && last_w) begin
                    for (int a = 0; a < 3; a++) begin
                        win_reg[0][a] <= win_reg[1][a];
                        win_reg[1][a] <= win_reg[2][a];
                        win_reg[2][a] <= pnt_reg[a];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // shared output converter
    bfdg_conv #(
        .ACC_WIDTH   (AW),
        .SHIFT_WIDTH (SH_W)
    ) u_conv (
        .aclk       (aclk),
        .load       (state_reg == ST_CV1),
        .acc_f      (acc_reg[0].f),
        .scale_log2 (k3),
        .coord      (conv_coord)
    );

`ifndef SYNTHESIS
    // input and output never open at the same time
    assert property (@(posedge aclk) disable iff (!aresetn) !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // point counter stays inside the segment
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (step_cnt_reg <= steps_m1))
        else $error("point counter past segment end");

    // the last point of a segment frees the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("not ready after last point");

    // an accepted control point is always counted in the window
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> (held_reg != 2'd0))
        else $error("window count lost a point");
`endif

endmodule

`default_nettype wire
